// ===== rtl/iolist_pkg.sv =====
// Package for the indexed ordered list: operation and status codes, the
// control struct that the top level broadcasts to every list cell and the read tree depth.
// No dependencies.
package iolist_pkg;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast along the row of cells in the cycle a request is taken.
  typedef struct packed {
    logic upd;  // legal set, insert or delete: cells update
    logic rd;   // legal get or delete: the addressed cell drives its tap
    op_t  op;
  } cell_ctl_t;

  localparam int TREE_FANIN = 16;

  // Number of registered levels in the read tree for a row of n cells.
  function automatic int tree_levels(input int n);
    int l;
    int span;
    l = 1;
    span = TREE_FANIN;
    while (span < n) begin
      l++;
      span = span * TREE_FANIN;
    end
    return l;
  endfunction

endpackage

// ===== rtl/iolist_cell.sv =====
// One element slot of the indexed ordered list, with its read tap.
// Depends on iolist_pkg.
module iolist_cell #(
  parameter int INDEX = 0,
  parameter int XW    = 8,
  parameter int W     = 32
) (
  input  logic                  clk,
  input  iolist_pkg::cell_ctl_t ctl,
  input  logic [XW-1:0]         pos,
  input  logic [W-1:0]          wr_val,
  input  logic [W-1:0]          lower_val,
  input  logic [W-1:0]          upper_val,
  output logic [W-1:0]          elem_val,
  output logic [W-1:0]          tap_val
);

  logic [W-1:0] elem_r, elem_nxt;
  logic [W-1:0] tap_r, tap_nxt;
  logic         hit, above;

  assign hit   = (pos == XW'(INDEX));
  assign above = (XW'(INDEX) > pos);

  always_comb begin
    elem_nxt = elem_r;
    if (ctl.upd) begin
      unique case (ctl.op)
        iolist_pkg::OP_SET: begin
          if (hit) elem_nxt = wr_val;
        end
        iolist_pkg::OP_INSERT: begin
          if (hit) elem_nxt = wr_val;
          else if (above) elem_nxt = lower_val;
        end
        iolist_pkg::OP_DELETE: begin
          if (hit || above) elem_nxt = upper_val;
        end
        default: begin
          elem_nxt = elem_r;
        end
      endcase
    end
    tap_nxt = (ctl.rd && hit) ? elem_r : '0;
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    tap_r  <= tap_nxt;
  end

  assign elem_val = elem_r;
  assign tap_val  = tap_r;

endmodule

// ===== rtl/iolist_or_tree.sv =====
// Registered OR-reduction tree that collects the single active cell tap.
// Depends on iolist_pkg for the fan-in and the number of levels.
module iolist_or_tree #(
  parameter int N = 128,
  parameter int W = 32
) (
  input  logic         clk,
  input  logic [W-1:0] leaf [N],
  output logic [W-1:0] root
);

  function automatic int level_size(input int n, input int l);
    int s;
    s = n;
    for (int i = 0; i < l; i++) s = (s + iolist_pkg::TREE_FANIN - 1) / iolist_pkg::TREE_FANIN;
    return s;
  endfunction

  localparam int LEVELS = iolist_pkg::tree_levels(N);

  // lvl[l] holds the registered outputs of tree level l.
  logic [W-1:0] lvl [LEVELS][N];

  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    localparam int PREV = level_size(N, l);
    localparam int SZ   = level_size(N, l + 1);
    for (genvar j = 0; j < SZ; j++) begin : g_node
      logic [W-1:0] acc;
      if (l == 0) begin : g_from_leaf
        always_comb begin
          acc = '0;
          for (int k = 0; k < iolist_pkg::TREE_FANIN; k++) begin
            if (j * iolist_pkg::TREE_FANIN + k < PREV)
              acc = acc | leaf[j * iolist_pkg::TREE_FANIN + k];
          end
        end
      end else begin : g_from_level
        always_comb begin
          acc = '0;
          for (int k = 0; k < iolist_pkg::TREE_FANIN; k++) begin
            if (j * iolist_pkg::TREE_FANIN + k < PREV)
              acc = acc | lvl[l-1][j * iolist_pkg::TREE_FANIN + k];
          end
        end
      end
      always_ff @(posedge clk) begin
        lvl[l][j] <= acc;
      end
    end
  end

  assign root = lvl[LEVELS-1][0];

endmodule

// ===== rtl/indexed_ordered_list.sv =====
// Top level of the indexed ordered list: request decode, length register,
// the row of list cells and the registered read tree.
// Depends on iolist_pkg, iolist_cell and iolist_or_tree.
//
// Usage:
//   The input channel carries one request per accepted item: an operation
//   (get, set, insert, delete), an element position and a new value. The
//   output channel returns one result per request: the value read by get or
//   removed by delete (zero otherwise), the list length after the request and
//   a status (ok, index out of range, list full on insert). An illegal request
//   changes nothing.
//   Every element sits in its own cell. In the cycle a request is accepted,
//   all cells compare their index with the position and write, shift up or
//   shift down together. The addressed cell registers its value on a tap;
//   a registered OR tree of fan-in 16 (two levels at a capacity of 128)
//   collects it. The result passes the tap register, the LEVELS registered
//   levels of the read tree and the output register; one request is in
//   flight at a time, so no request is accepted while one is pending.
//   A finished result waits in the output register while the receiver stalls;
//   the next request is accepted in the cycle that result is taken.
//   Reset empties the list (length zero); element contents are left as they
//   are and are never read before they are written.
module indexed_ordered_list #(
  parameter int CAPACITY      = 128,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] operation, [9:2] position, [41:10] new_value, [47:42] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] read_value, [39:32] list_length, [41:40] status, [47:42] zero
  output logic [47:0] out_tdata
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int XW   = (CNTW > 8) ? CNTW : 8;
  localparam int W    = ELEMENT_WIDTH;

  // Request fields.
  iolist_pkg::op_t op;
  logic [7:0]      position;
  logic [31:0]     new_value;
  logic [XW-1:0]   pos_x, cnt_x;
  logic [63:0]     val_wide;
  logic [W-1:0]    wr_val;

  assign op        = iolist_pkg::op_t'(in_tdata[1:0]);
  assign position  = in_tdata[9:2];
  assign new_value = in_tdata[41:10];
  assign pos_x     = XW'(position);
  assign val_wide  = 64'(new_value);
  assign wr_val    = val_wide[W-1:0];

  logic [CNTW-1:0] count_r, count_nxt;
  assign cnt_x = XW'(count_r);

  logic accept;
  assign accept = in_tvalid && in_tready;

  // Legality of the request against the current length.
  logic range_bad, full;
  iolist_pkg::status_t status_now;
  always_comb begin
    if (op == iolist_pkg::OP_INSERT) range_bad = (pos_x > cnt_x);
    else range_bad = (pos_x >= cnt_x);
    full = (count_r == CNTW'(CAPACITY));
    if (range_bad) status_now = iolist_pkg::ST_RANGE;
    else if (op == iolist_pkg::OP_INSERT && full) status_now = iolist_pkg::ST_FULL;
    else status_now = iolist_pkg::ST_OK;
  end

  logic legal;
  iolist_pkg::cell_ctl_t ctl;
  assign legal   = (status_now == iolist_pkg::ST_OK);
  assign ctl.op  = op;
  assign ctl.upd = accept && legal && (op != iolist_pkg::OP_GET);
  assign ctl.rd  = accept && legal &&
                   (op == iolist_pkg::OP_GET || op == iolist_pkg::OP_DELETE);

  always_comb begin
    count_nxt = count_r;
    if (accept && legal) begin
      if (op == iolist_pkg::OP_INSERT) count_nxt = count_r + CNTW'(1);
      else if (op == iolist_pkg::OP_DELETE) count_nxt = count_r - CNTW'(1);
    end
  end

  // Row of cells; each sees its neighbors for shifting.
  logic [W-1:0] elem [CAPACITY];
  logic [W-1:0] tap  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [W-1:0] lower_val, upper_val;
    if (i == 0) begin : g_bottom
      assign lower_val = elem[i];
    end else begin : g_lower
      assign lower_val = elem[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign upper_val = elem[i];
    end else begin : g_upper
      assign upper_val = elem[i+1];
    end
    iolist_cell #(
      .INDEX (i),
      .XW    (XW),
      .W     (W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (pos_x),
      .wr_val    (wr_val),
      .lower_val (lower_val),
      .upper_val (upper_val),
      .elem_val  (elem[i]),
      .tap_val   (tap[i])
    );
  end

  logic [W-1:0] tree_root;
  iolist_or_tree #(
    .N (CAPACITY),
    .W (W)
  ) u_tree (
    .clk  (clk),
    .leaf (tap),
    .root (tree_root)
  );

  localparam int LEVELS = iolist_pkg::tree_levels(CAPACITY);
  localparam int STW    = $clog2(LEVELS + 1);

  // Sequencing: a pending request waits until its tap has crossed the tree.
  logic                pend_r, pend_nxt;
  logic [STW-1:0]      wait_r, wait_nxt;
  logic [7:0]          len_r, len_nxt;
  iolist_pkg::status_t stat_r, stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_val_r, out_val_nxt;
  logic [7:0]          out_len_r, out_len_nxt;
  iolist_pkg::status_t out_stat_r, out_stat_nxt;
  logic [XW-1:0]       cnt_nxt_x;
  logic [63:0]         root_wide;

  assign cnt_nxt_x = XW'(count_nxt);
  assign root_wide = 64'(tree_root);
  assign in_tready = !pend_r && (!out_valid_r || out_tready);

  always_comb begin
    pend_nxt      = pend_r;
    wait_nxt      = wait_r;
    len_nxt       = len_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_len_nxt   = out_len_r;
    out_stat_nxt  = out_stat_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (accept) begin
      pend_nxt = 1'b1;
      wait_nxt = STW'(LEVELS);
      len_nxt  = cnt_nxt_x[7:0];
      stat_nxt = status_now;
    end else if (pend_r) begin
      if (wait_r != '0) begin
        wait_nxt = wait_r - STW'(1);
      end else begin
        pend_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        out_val_nxt   = root_wide[31:0];
        out_len_nxt   = len_r;
        out_stat_nxt  = stat_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r      <= len_nxt;
    stat_r     <= stat_nxt;
    out_val_r  <= out_val_nxt;
    out_len_r  <= out_len_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_stat_r, out_len_r, out_val_r};

endmodule

// ===== dv/tb_indexed_ordered_list.sv =====
// Self-checking testbench for indexed_ordered_list: directed, fill-to-capacity,
// backpressure and random request streams checked against an in-bench list model.
// Depends on iolist_pkg and the indexed_ordered_list RTL.
`timescale 1ns / 1ps

module tb_indexed_ordered_list;

  localparam int CAPACITY     = 128;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int PRINT_LIMIT  = 30;
  localparam int RANDOM_COUNT = 660;
  localparam int QUIET_TAIL   = 150;

  // One expected response, field by field.
  typedef struct packed {
    logic [31:0]         value;
    logic [7:0]          length;
    iolist_pkg::status_t status;
  } list_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [1:0] operation, [9:2] position, [41:10] new_value, [47:42] zero
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [31:0] read_value, [39:32] list_length, [41:40] status, [47:42] zero
  logic [47:0] out_tdata;

  // Shadow copy of the list contents and its length.
  logic [31:0]  shadow_elems [CAPACITY];
  int           shadow_len;
  list_result_t pending_results [$];

  int  mismatch_count;
  int  requests_sent;
  int  responses_seen;
  int  ok_count;
  int  range_count;
  int  full_count;
  int  peak_len;
  int  cycle_count;
  bit  idle_on;
  int  hold_request;
  int  hold_left;
  int  stall_left;

  indexed_ordered_list DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow list and returns what the block should answer.
  function automatic list_result_t apply_list_request(input iolist_pkg::op_t op,
                                                      input logic [7:0] pos,
                                                      input logic [31:0] val);
    list_result_t r;
    r.value  = '0;
    r.status = iolist_pkg::ST_OK;
    case (op)
      iolist_pkg::OP_GET: begin
        if (pos >= shadow_len) r.status = iolist_pkg::ST_RANGE;
        else r.value = shadow_elems[pos];
      end
      iolist_pkg::OP_SET: begin
        if (pos >= shadow_len) r.status = iolist_pkg::ST_RANGE;
        else shadow_elems[pos] = val;
      end
      iolist_pkg::OP_INSERT: begin
        // The index test comes before the full test.
        if (pos > shadow_len) r.status = iolist_pkg::ST_RANGE;
        else if (shadow_len >= CAPACITY) r.status = iolist_pkg::ST_FULL;
        else begin
          for (int k = shadow_len; k > pos; k--) shadow_elems[k] = shadow_elems[k - 1];
          shadow_elems[pos] = val;
          shadow_len++;
        end
      end
      default: begin
        if (pos >= shadow_len) r.status = iolist_pkg::ST_RANGE;
        else begin
          r.value = shadow_elems[pos];
          for (int k = pos; k + 1 < shadow_len; k++) shadow_elems[k] = shadow_elems[k + 1];
          shadow_len--;
        end
      end
    endcase
    r.length = shadow_len[7:0];
    case (r.status)
      iolist_pkg::ST_OK:    ok_count++;
      iolist_pkg::ST_RANGE: range_count++;
      default:              full_count++;
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
    return r;
  endfunction

  // Offers one request, waits for the handshake and records the expected response.
  // Valid stays high after the handshake unless an idle burst follows, so
  // back-to-back calls stream without a gap.
  task automatic send_request(input iolist_pkg::op_t op, input logic [7:0] pos,
                              input logic [31:0] val);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, pos, op};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_list_request(op, pos, val));
    requests_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] expected,
                                 input logic [31:0] actual);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, expected,
               actual);
    mismatch_count++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Response checker: every accepted response is matched with the oldest expectation.
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      responses_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected response", 32'd0, out_tdata[31:0]);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[31:0] !== exp_r.value)
          report_mismatch("read_value", exp_r.value, out_tdata[31:0]);
        if (out_tdata[39:32] !== exp_r.length)
          report_mismatch("list_length", 32'(exp_r.length), 32'(out_tdata[39:32]));
        if (out_tdata[41:40] !== exp_r.status)
          report_mismatch("status", 32'(exp_r.status), 32'(out_tdata[41:40]));
        if (out_tdata[47:42] !== 6'b0)
          report_mismatch("padding", 32'd0, 32'(out_tdata[47:42]));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request from a test.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Requests against an empty list: every one of them must be rejected.
  task automatic test_empty_list();
    send_request(iolist_pkg::OP_GET, 8'd0, 32'h1234_5678);
    send_request(iolist_pkg::OP_SET, 8'd0, 32'hFFFF_FFFF);
    send_request(iolist_pkg::OP_DELETE, 8'd0, 32'd0);      // pop on an empty list
    send_request(iolist_pkg::OP_INSERT, 8'd1, 32'hFFFF_FFFF);
    send_request(iolist_pkg::OP_INSERT, 8'd255, 32'd0);
    send_request(iolist_pkg::OP_GET, 8'd255, 32'd0);
  endtask

  // Each operation on a short list, including head, middle and tail positions.
  task automatic test_basic_ops();
    send_request(iolist_pkg::OP_INSERT, 8'd0, 32'hFFFF_FFFF);   // push into empty list
    send_request(iolist_pkg::OP_INSERT, 8'd1, 32'h0000_0000);   // push at the length
    send_request(iolist_pkg::OP_INSERT, 8'd1, 32'hA5A5_5A5A);   // insert in the middle
    send_request(iolist_pkg::OP_INSERT, 8'd0, 32'h8000_0001);   // insert at the head
    send_request(iolist_pkg::OP_GET, 8'd0, 32'd0);
    send_request(iolist_pkg::OP_GET, 8'd3, 32'd0);
    send_request(iolist_pkg::OP_SET, 8'd2, 32'h0F0F_F0F0);
    send_request(iolist_pkg::OP_GET, 8'd2, 32'hFFFF_FFFF);
    send_request(iolist_pkg::OP_GET, 8'd4, 32'd0);              // index equal to the length
    send_request(iolist_pkg::OP_SET, 8'd4, 32'd7);
    send_request(iolist_pkg::OP_DELETE, 8'd4, 32'd0);
    send_request(iolist_pkg::OP_INSERT, 8'd6, 32'd9);           // beyond the length
    send_request(iolist_pkg::OP_DELETE, 8'd1, 32'd0);           // delete from the middle
    send_request(iolist_pkg::OP_DELETE, 8'd2, 32'd0);           // pop at length minus one
    send_request(iolist_pkg::OP_GET, 8'd1, 32'd0);
    send_request(iolist_pkg::OP_DELETE, 8'd0, 32'd0);
  endtask

  // Fills the list to capacity, probes the full-list behavior and drains it again.
  task automatic test_fill_and_full();
    while (shadow_len < CAPACITY)
      send_request(iolist_pkg::OP_INSERT, 8'($urandom_range(0, shadow_len)), pick_value());
    send_request(iolist_pkg::OP_INSERT, 8'd0, 32'hDEAD_BEEF);        // full at the head
    send_request(iolist_pkg::OP_INSERT, 8'd128, 32'hDEAD_BEEF);      // full at the tail
    send_request(iolist_pkg::OP_INSERT, 8'($urandom_range(1, 127)), 32'd1);
    send_request(iolist_pkg::OP_INSERT, 8'd129, 32'd1);              // range wins over full
    send_request(iolist_pkg::OP_INSERT, 8'd255, 32'hFFFF_FFFF);
    send_request(iolist_pkg::OP_GET, 8'd127, 32'd0);
    send_request(iolist_pkg::OP_GET, 8'd128, 32'd0);
    send_request(iolist_pkg::OP_SET, 8'd127, 32'hFFFF_FFFF);
    send_request(iolist_pkg::OP_GET, 8'd127, 32'd0);
    send_request(iolist_pkg::OP_DELETE, 8'd127, 32'd0);              // pop from a full list
    send_request(iolist_pkg::OP_INSERT, 8'd0, 32'h0000_0001);        // refill at the head
    send_request(iolist_pkg::OP_DELETE, 8'd0, 32'd0);
    while (shadow_len > 0)
      send_request(iolist_pkg::OP_DELETE, 8'($urandom_range(0, shadow_len - 1)),
                   pick_value());
    send_request(iolist_pkg::OP_DELETE, 8'd0, 32'd0);
  endtask

  // Long receiver hold-off: the block keeps its result and must stall the input.
  task automatic test_backpressure();
    send_request(iolist_pkg::OP_INSERT, 8'd0, pick_value());
    send_request(iolist_pkg::OP_INSERT, 8'd1, pick_value());
    hold_request = 300;
    repeat (8)
      send_request(iolist_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                   pick_value());
  endtask

  // Mostly legal requests whose length wanders between empty and full, plus noise
  // with arbitrary positions. The tail of the stream runs with no idling at all.
  task automatic test_random_stream(input int n);
    bit              growing;
    int              roll;
    iolist_pkg::op_t op;
    logic [7:0]      pos;
    growing = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i == n - QUIET_TAIL) idle_on = 1'b0;
      if (shadow_len >= CAPACITY) growing = 1'b0;
      else if (shadow_len <= 2) growing = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        op  = iolist_pkg::op_t'($urandom_range(0, 3));
        pos = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                   : 8'(shadow_len + $urandom_range(0, 255 - shadow_len));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < (growing ? 45 : 15)) op = iolist_pkg::OP_INSERT;
        else if (roll < 60) op = iolist_pkg::OP_DELETE;
        else if (roll < 80) op = iolist_pkg::OP_GET;
        else op = iolist_pkg::OP_SET;
        if (shadow_len == 0) op = iolist_pkg::OP_INSERT;
        pos = (op == iolist_pkg::OP_INSERT) ? 8'($urandom_range(0, shadow_len))
                                            : 8'($urandom_range(0, shadow_len - 1));
      end
      send_request(op, pos, pick_value());
    end
  endtask

  initial begin
    int waited;
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    shadow_len     = 0;
    mismatch_count = 0;
    requests_sent  = 0;
    responses_seen = 0;
    ok_count       = 0;
    range_count    = 0;
    full_count     = 0;
    peak_len       = 0;
    cycle_count    = 0;
    hold_request   = 0;
    hold_left      = 0;
    stall_left     = 0;
    idle_on        = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_basic_ops();
    test_fill_and_full();
    test_backpressure();
    test_random_stream(RANDOM_COUNT);

    // Stop offering, then wait for every outstanding response.
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (pending_results.size() > 0)
      report_mismatch("responses never returned", 32'd0, 32'(pending_results.size()));

    $display("Covered %0d requests and %0d responses: %0d ok, %0d out of range, %0d full",
             requests_sent, responses_seen, ok_count, range_count, full_count);
    $display("Peak list length %0d of %0d, %0d mismatches", peak_len, CAPACITY,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/iolist_pkg.sv
rtl/iolist_cell.sv
rtl/iolist_or_tree.sv
rtl/indexed_ordered_list.sv
dv/tb_indexed_ordered_list.sv
